// ===== sv/rht_pkg.sv =====
`timescale 1ns / 1ps
package rht_pkg;
	localparam int LANES      = 4;
	localparam int MAX_DIM    = 256;
	localparam int ROWS       = MAX_DIM / LANES;
	localparam int ROW_W      = $clog2(ROWS);
	localparam int PAIR_W     = ROW_W - 1;
	localparam int PASS_W     = $clog2(ROW_W);
	localparam int IN_W       = 16;
	localparam int PROD_W     = 18;
	localparam int SUM_W      = 26;
	localparam int NORM_W     = 15;
	localparam int MUL_W      = SUM_W + NORM_W;
	localparam int OUT_W      = 20;
	localparam int FACTOR_FRAC = 14;
	localparam int NORM_FRAC  = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [1:0] SIZE_64  = 2'd0;
	localparam logic [1:0] SIZE_128 = 2'd1;
	localparam logic [1:0] SIZE_256 = 2'd2;

	typedef struct packed {
		logic signed [IN_W-1:0] q_elem_0;
		logic signed [IN_W-1:0] q_elem_1;
		logic signed [IN_W-1:0] q_elem_2;
		logic signed [IN_W-1:0] q_elem_3;
		logic signed [IN_W-1:0] sign_0;
		logic signed [IN_W-1:0] sign_1;
		logic signed [IN_W-1:0] sign_2;
		logic signed [IN_W-1:0] sign_3;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] out_elem_0;
		logic signed [OUT_W-1:0] out_elem_1;
		logic signed [OUT_W-1:0] out_elem_2;
		logic signed [OUT_W-1:0] out_elem_3;
		logic                    last_of_vector;
	} out_item_t;

	typedef logic [LANES-1:0][PROD_W-1:0] prod_row_t;
	typedef logic [LANES-1:0][SUM_W-1:0]  sum_row_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic             last;
		prod_row_t        prod;
	} q_entry_t;

	function automatic logic [ROW_W-1:0] rows_minus1(input logic [1:0] sel);
		case (sel)
			SIZE_64:  rows_minus1 = ROW_W'(64 / LANES - 1);
			SIZE_128: rows_minus1 = ROW_W'(128 / LANES - 1);
			default:  rows_minus1 = ROW_W'(ROWS - 1);
		endcase
	endfunction

	function automatic logic [PASS_W-1:0] last_pass(input logic [1:0] sel);
		case (sel)
			SIZE_64:  last_pass = PASS_W'($clog2(64 / LANES) - 1);
			SIZE_128: last_pass = PASS_W'($clog2(128 / LANES) - 1);
			default:  last_pass = PASS_W'(ROW_W - 1);
		endcase
	endfunction

	function automatic logic signed [NORM_W-1:0] norm_for(input logic [1:0] sel);
		case (sel)
			SIZE_64:  norm_for = NORM_W'(8192);
			SIZE_128: norm_for = NORM_W'(5793);
			default:  norm_for = NORM_W'(4096);
		endcase
	endfunction
endpackage

// ===== sv/rht_ram.sv =====
`timescale 1ns / 1ps
module rht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

// ===== sv/rht_front.sv =====
`timescale 1ns / 1ps
module rht_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         size_sel,
	input  logic               clear,
	input  logic               push,
	output logic               full,
	input  rht_pkg::in_item_t  in_item,
	output logic               q_valid,
	input  logic               q_pop,
	output rht_pkg::q_entry_t  q_entry
);
	import rht_pkg::*;

	logic [ROW_W-1:0]   count_q;
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   fill_q;
	q_entry_t           fifo_q [FIFO_DEPTH];
	q_entry_t           new_entry;
	logic               accept;
	logic               is_last;
	logic signed [IN_W-1:0] qv [LANES];
	logic signed [IN_W-1:0] sv [LANES];
	logic signed [2*IN_W-1:0] prod [LANES];
	logic signed [2*IN_W:0]   biased [LANES];

	assign qv[0] = in_item.q_elem_0;
	assign qv[1] = in_item.q_elem_1;
	assign qv[2] = in_item.q_elem_2;
	assign qv[3] = in_item.q_elem_3;
	assign sv[0] = in_item.sign_0;
	assign sv[1] = in_item.sign_1;
	assign sv[2] = in_item.sign_2;
	assign sv[3] = in_item.sign_3;

	assign full    = (fill_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign q_valid = (fill_q != '0);
	assign q_entry = fifo_q[rd_ptr_q];
	assign accept  = push && !full;
	assign is_last = (count_q == rows_minus1(size_sel));

	always_comb begin
		new_entry.row  = count_q;
		new_entry.last = is_last;
		for (int i = 0; i < LANES; i++) begin
			prod[i]   = qv[i] * sv[i];
			// round half up, then drop the fraction
			biased[i] = {prod[i][2*IN_W-1], prod[i]} + (2*IN_W+1)'(1 << (FACTOR_FRAC - 1));
			new_entry.prod[i] = PROD_W'(biased[i] >>> FACTOR_FRAC);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (clear) begin
				count_q <= '0;
			end else if (accept) begin
				count_q <= is_last ? '0 : count_q + 1'b1;
			end
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fill_q <= fill_q + (FIFO_AW+1)'(accept) - (FIFO_AW+1)'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fifo_q[wr_ptr_q] <= new_entry;
		end
	end
endmodule

// ===== sv/rht_back.sv =====
`timescale 1ns / 1ps
module rht_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         size_sel,
	input  logic               q_valid,
	output logic               q_pop,
	input  rht_pkg::q_entry_t  q_entry,
	output logic               empty,
	input  logic               pop,
	output rht_pkg::out_item_t out_item
);
	import rht_pkg::*;

	localparam logic [2:0] S_LOAD = 3'd0;
	localparam logic [2:0] S_RA   = 3'd1;
	localparam logic [2:0] S_RB   = 3'd2;
	localparam logic [2:0] S_WA   = 3'd3;
	localparam logic [2:0] S_WB   = 3'd4;
	localparam logic [2:0] S_OR   = 3'd5;
	localparam logic [2:0] S_OM   = 3'd6;
	localparam logic [2:0] S_OP   = 3'd7;

	logic [2:0]        state_q;
	logic [PASS_W-1:0] k_q;
	logic [PAIR_W-1:0] p_q;
	logic [ROW_W-1:0]  row_q;
	sum_row_t          a_q;
	sum_row_t          b_q;
	logic signed [MUL_W-1:0] prod_s1 [LANES];
	logic              out_valid_q;
	out_item_t         out_q;

	logic              wr_en;
	logic [ROW_W-1:0]  wr_addr;
	sum_row_t          wr_data;
	logic [ROW_W-1:0]  rd_addr;
	sum_row_t          rd_data;
	logic [ROW_W-1:0]  mask;
	logic [ROW_W-1:0]  pe;
	logic [ROW_W-1:0]  addr_a;
	logic [ROW_W-1:0]  addr_b;
	logic [PAIR_W-1:0] last_pair;
	sum_row_t          load_row;
	sum_row_t          sum_row;
	sum_row_t          diff_row;
	logic signed [SUM_W-1:0] x [LANES];
	logic signed [MUL_W-1:0] rnd [LANES];
	logic signed [OUT_W-1:0] sat [LANES];
	logic              out_load;

	assign mask      = (ROW_W'(1) << k_q) - 1'b1;
	assign pe        = {1'b0, p_q};
	assign addr_a    = ((pe & ~mask) << 1) | (pe & mask);
	assign addr_b    = addr_a | (ROW_W'(1) << k_q);
	assign last_pair = PAIR_W'(rows_minus1(size_sel) >> 1);
	assign q_pop     = (state_q == S_LOAD) && q_valid;
	assign out_load  = (state_q == S_OP) && (!out_valid_q || pop);
	assign empty     = !out_valid_q;
	assign out_item  = out_q;

	// butterflies of width one and two stay inside a row
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			x[i] = SUM_W'($signed(q_entry.prod[i]));
		end
		load_row[0] = x[0] + x[1] + x[2] + x[3];
		load_row[1] = x[0] - x[1] + x[2] - x[3];
		load_row[2] = x[0] + x[1] - x[2] - x[3];
		load_row[3] = x[0] - x[1] - x[2] + x[3];
		for (int i = 0; i < LANES; i++) begin
			sum_row[i]  = a_q[i] + rd_data[i];
			diff_row[i] = a_q[i] - b_q[i];
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_a;
		wr_data = sum_row;
		case (state_q)
			S_LOAD: begin
				wr_en   = q_valid;
				wr_addr = q_entry.row;
				wr_data = load_row;
			end
			S_WA: begin
				wr_en = 1'b1;
			end
			S_WB: begin
				wr_en   = 1'b1;
				wr_addr = addr_b;
				wr_data = diff_row;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		case (state_q)
			S_RB:    rd_addr = addr_b;
			S_OR:    rd_addr = row_q;
			default: rd_addr = addr_a;
		endcase
	end

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			rnd[i] = (prod_s1[i] + MUL_W'(1 << (NORM_FRAC - 1))) >>> NORM_FRAC;
			if (rnd[i] > MUL_W'((1 << (OUT_W - 1)) - 1)) begin
				sat[i] = {1'b0, {(OUT_W-1){1'b1}}};
			end else if (rnd[i] < -MUL_W'(1 << (OUT_W - 1))) begin
				sat[i] = {1'b1, {(OUT_W-1){1'b0}}};
			end else begin
				sat[i] = OUT_W'(rnd[i]);
			end
		end
	end

	rht_ram #(
		.WIDTH(LANES * SUM_W),
		.DEPTH(ROWS)
	) u_buf (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			k_q         <= '0;
			p_q         <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (q_valid && q_entry.last) begin
						k_q     <= '0;
						p_q     <= '0;
						state_q <= S_RA;
					end
				end
				S_RA: state_q <= S_RB;
				S_RB: state_q <= S_WA;
				S_WA: state_q <= S_WB;
				S_WB: begin
					if (p_q != last_pair) begin
						p_q     <= p_q + 1'b1;
						state_q <= S_RA;
					end else if (k_q != last_pass(size_sel)) begin
						p_q     <= '0;
						k_q     <= k_q + 1'b1;
						state_q <= S_RA;
					end else begin
						row_q   <= '0;
						state_q <= S_OR;
					end
				end
				S_OR: state_q <= S_OM;
				S_OM: state_q <= S_OP;
				S_OP: begin
					if (out_load) begin
						if (row_q == rows_minus1(size_sel)) begin
							state_q <= S_LOAD;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= S_OR;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RB) begin
			a_q <= rd_data;
		end
		if (state_q == S_WA) begin
			b_q <= rd_data;
		end
		if (state_q == S_OM) begin
			for (int i = 0; i < LANES; i++) begin
				prod_s1[i] <= $signed(rd_data[i]) * norm_for(size_sel);
			end
		end
		if (out_load) begin
			out_q.out_elem_0     <= sat[0];
			out_q.out_elem_1     <= sat[1];
			out_q.out_elem_2     <= sat[2];
			out_q.out_elem_3     <= sat[3];
			out_q.last_of_vector <= (row_q == rows_minus1(size_sel));
		end
	end
endmodule

// ===== sv/randomized_hadamard_transform.sv =====
`timescale 1ns / 1ps
// Randomized Walsh-Hadamard transform of one vector of 64, 128 or 256 elements.
// Input is a queue write side: an item of four samples and four Q2.14 factors
// is taken on a clock edge with push high and full low. A four-entry queue
// holds scaled products while the transform engine is busy.
// Results are a queue read side: while empty is low the oldest result sits on
// out_item, taken on an edge with pop high; last_of_vector marks the final one.
// A stalled reader simply holds the result; the engine waits on it.
// Config: cfg_data sets the vector length (0: 64, 1: 128, 2 or 3: 256) on an
// edge with cfg_valid high; cfg_ready is always high. A write drops any
// partial vector. Write it only while the block is idle.
// Flow: the engine loads one item per cycle from the queue while in its load
// state. After the last item it runs log2(n/4) passes of n/8 row pairs; each pair
// reads row A, reads row B, then writes the sum to A and the difference to B (one
// shared buffer read port). It then reads, scales and emits each result row in turn.
// Reset: size returns to 256, queues empty, item count cleared.
module randomized_hadamard_transform (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  rht_pkg::in_item_t  in_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_data,
	output logic               empty,
	input  logic               pop,
	output rht_pkg::out_item_t out_item
);
	import rht_pkg::*;

	logic [1:0] size_q;
	logic       cfg_write;
	logic       q_valid;
	logic       q_pop;
	q_entry_t   q_entry;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_256;
		end else if (cfg_write) begin
			size_q <= cfg_data;
		end
	end

	rht_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.size_sel(size_q),
		.clear   (cfg_write),
		.push    (push),
		.full    (full),
		.in_item (in_item),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_entry (q_entry)
	);

	rht_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.size_sel(size_q),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_entry (q_entry),
		.empty   (empty),
		.pop     (pop),
		.out_item(out_item)
	);

`ifndef ASSERT_OFF
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("queue popped while empty");
	a_full_valid: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> q_valid) else $error("queue full but not valid");
`endif
endmodule
